// File: design/swmi_pkg.sv
// shared constants and control types for the sliding window minimum block
`timescale 1ns / 1ps

package swmi_pkg;

    localparam int WINDOW_MAX = 64;
    localparam int DATA_W     = 32;
    localparam int WS_W       = 7;
    localparam int PTR_W      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_W      = $clog2(WINDOW_MAX + 1);
    localparam int EW_W       = (WS_W > CNT_W) ? WS_W : CNT_W;

    localparam logic [DATA_W-1:0] POS_MAX = '1;

    // one stored candidate
    typedef struct packed {
        logic        [DATA_W-1:0] pos;
        logic signed [DATA_W-1:0] value;
    } t_entry;

    // controller to datapath
    typedef struct packed {
        logic item_ready;
        logic pop_head;
        logic pop_tail;
        logic push;
        logic finish;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic item_valid;
        logic head_expired;
        logic tail_greater;
        logic emit_blocked;
    } t_status;

endpackage

// File: design/swmi_if.sv
// handshake interfaces for the sample, result and configuration channels
`timescale 1ns / 1ps

interface swmi_item_if;
    import swmi_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] sample;
    logic                     last_item;
    modport source (output valid, output sample, output last_item, input ready);
    modport sink   (input valid, input sample, input last_item, output ready);
endinterface

interface swmi_result_if;
    import swmi_pkg::*;
    logic                     valid;
    logic                     ready;
    logic        [DATA_W-1:0] min_position;
    logic signed [DATA_W-1:0] min_value;
    logic                     position_overflow;
    modport source (output valid, output min_position, output min_value,
                    output position_overflow, input ready);
    modport sink   (input valid, input min_position, input min_value,
                    input position_overflow, output ready);
endinterface

interface swmi_cfg_if;
    import swmi_pkg::*;
    logic            valid;
    logic            ready;
    logic [WS_W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: design/swmi_datapath.sv
// candidate list memory, pointers, position counter and output register
`timescale 1ns / 1ps

module swmi_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  swmi_pkg::t_cmd    i_cmd,
    output swmi_pkg::t_status o_status,
    swmi_item_if.sink         i_item,
    swmi_result_if.source     o_result,
    swmi_cfg_if.sink          i_cfg
);
    import swmi_pkg::*;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(WINDOW_MAX - 1)) return '0;
        return p + 1'b1;
    endfunction

    function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
        if (p == '0) return PTR_W'(WINDOW_MAX - 1);
        return p - 1'b1;
    endfunction

    logic        [WS_W-1:0]   r_window_size;
    logic signed [DATA_W-1:0] r_sample;
    logic                     r_last;
    logic        [DATA_W-1:0] r_pos;
    logic        [DATA_W-1:0] r_next_pos;
    logic                     r_sat;
    logic        [PTR_W-1:0]  r_head, n_head;
    logic        [PTR_W-1:0]  r_tail, n_tail;
    logic        [CNT_W-1:0]  r_count, n_count;
    t_entry                   r_mem [WINDOW_MAX];
    t_entry                   r_rd_head;
    t_entry                   r_rd_tail;
    logic                     r_out_valid;
    logic        [DATA_W-1:0] r_out_pos;
    logic signed [DATA_W-1:0] r_out_value;
    logic                     r_out_ovf;

    logic [EW_W-1:0] w_ws;
    logic            w_item_xfer;
    logic            w_window_full;
    logic            w_full_list;
    t_entry          w_head_now;

    assign i_cfg.ready   = 1'b1;
    assign i_item.ready  = i_cmd.item_ready;
    assign w_item_xfer   = i_cmd.item_ready && i_item.valid;
    assign w_full_list   = (r_count == CNT_W'(WINDOW_MAX));

    // zero acts as one, oversize clamps to the list depth
    always_comb begin
        if (r_window_size == '0) begin
            w_ws = EW_W'(1);
        end else if (EW_W'(r_window_size) > EW_W'(WINDOW_MAX)) begin
            w_ws = EW_W'(WINDOW_MAX);
        end else begin
            w_ws = EW_W'(r_window_size);
        end
    end

    assign w_window_full = ({1'b0, r_pos} + (DATA_W + 1)'(1)) >= (DATA_W + 1)'(w_ws);

    assign o_status.item_valid   = i_item.valid;
    assign o_status.head_expired = (r_count != '0) &&
        (({1'b0, r_rd_head.pos} + (DATA_W + 1)'(w_ws)) <= {1'b0, r_pos});
    assign o_status.tail_greater = (r_count != '0) && (r_rd_tail.value > r_sample);
    assign o_status.emit_blocked = w_window_full && r_out_valid && !o_result.ready;

    // a lone entry was just written at the head address, so take it from the item
    assign w_head_now = (r_count == CNT_W'(1)) ? t_entry'{pos: r_pos, value: r_sample}
                                               : r_rd_head;

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (i_cmd.pop_head) begin
            n_head  = ptr_inc(r_head);
            n_count = r_count - 1'b1;
        end else if (i_cmd.pop_tail) begin
            n_tail  = ptr_dec(r_tail);
            n_count = r_count - 1'b1;
        end else if (i_cmd.push) begin
            n_tail = ptr_inc(r_tail);
            if (w_full_list) begin
                n_head = ptr_inc(r_head);
            end else begin
                n_count = r_count + 1'b1;
            end
        end else if (i_cmd.finish && r_last) begin
            n_head  = '0;
            n_tail  = PTR_W'(WINDOW_MAX - 1);
            n_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[ptr_inc(r_tail)] <= t_entry'{pos: r_pos, value: r_sample};
        end
        r_rd_head <= r_mem[n_head];
        r_rd_tail <= r_mem[n_tail];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= WS_W'(1);
            r_next_pos    <= '0;
            r_sat         <= 1'b0;
            r_head        <= '0;
            r_tail        <= PTR_W'(WINDOW_MAX - 1);
            r_count       <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            if (i_cfg.valid) begin
                r_window_size <= i_cfg.data;
            end
            if (w_item_xfer) begin
                if (r_next_pos == POS_MAX) begin
                    r_sat <= 1'b1;
                end else begin
                    r_next_pos <= r_next_pos + 1'b1;
                end
            end
            if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.finish) begin
                if (w_window_full) begin
                    r_out_valid <= 1'b1;
                end
                if (r_last) begin
                    r_next_pos <= '0;
                    r_sat      <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_item_xfer) begin
            r_sample <= i_item.sample;
            r_last   <= i_item.last_item;
            r_pos    <= r_next_pos;
        end
        if (i_cmd.finish && w_window_full) begin
            r_out_pos   <= w_head_now.pos;
            r_out_value <= w_head_now.value;
            r_out_ovf   <= r_sat;
        end
    end

    assign o_result.valid             = r_out_valid;
    assign o_result.min_position      = r_out_pos;
    assign o_result.min_value         = r_out_value;
    assign o_result.position_overflow = r_out_ovf;

endmodule

// File: design/swmi_ctrl.sv
// sequencer that steps one sample through the candidate list updates
`timescale 1ns / 1ps

module swmi_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  swmi_pkg::t_status i_status,
    output swmi_pkg::t_cmd    o_cmd
);
    import swmi_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HEAD,
        S_TAIL,
        S_PUSH,
        S_EMIT
    } t_state;

    t_state r_state;

    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_IDLE: o_cmd.item_ready = 1'b1;
            S_HEAD: o_cmd.pop_head   = i_status.head_expired;
            S_TAIL: o_cmd.pop_tail   = i_status.tail_greater;
            S_PUSH: o_cmd.push       = 1'b1;
            S_EMIT: o_cmd.finish     = !i_status.emit_blocked;
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_status.item_valid) r_state <= S_HEAD;
                end
                S_HEAD: begin
                    if (!i_status.head_expired) r_state <= S_TAIL;
                end
                S_TAIL: begin
                    if (!i_status.tail_greater) r_state <= S_PUSH;
                end
                S_PUSH: r_state <= S_EMIT;
                S_EMIT: begin
                    if (!i_status.emit_blocked) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// File: design/sliding_window_min_index_core.sv
// top level of the sliding window minimum with position
`timescale 1ns / 1ps

// channel   dir  handshake        payload
// i_item    in   valid / ready    sample, last_item
// o_result  out  valid / ready    min_position, min_value, position_overflow
// i_cfg     in   valid / ready    data (window size)
//
// a sample passes through the head drop, tail drop, append and deliver steps from one transfer
// to the next, plus one step per candidate dropped from the head or tail of the list; each
// candidate is dropped once; a result becomes valid from the deliver step of its sample
// the drop loops step one entry a cycle through the candidate memory read ports
// synchronous active-low reset empties the list and zeroes the position counter
// a held result stalls only the final step while the output register is occupied

module sliding_window_min_index_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    swmi_item_if.sink     i_item,
    swmi_result_if.source o_result,
    swmi_cfg_if.sink      i_cfg
);
    import swmi_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    // sequencer: idle, drop expired heads, drop larger tails, append, deliver
    swmi_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    // monotonic candidate list in a circular buffer with head and tail reads
    swmi_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_status (w_status),
        .i_item   (i_item),
        .o_result (o_result),
        .i_cfg    (i_cfg)
    );

endmodule

// File: dv/tb_sliding_window_min_index_core.sv
// self-checking testbench for the sliding window minimum with position
`timescale 1ns / 1ps

module tb_sliding_window_min_index_core;
    import swmi_pkg::*;

    localparam int RANDOM_SAMPLES = 1030;
    // a sample may walk the whole candidate list on top of its regular steps
    localparam int SETTLE_CYCLES  = 150;
    localparam int STALL_LIMIT    = 4000;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic        [DATA_W-1:0] pos;
        logic signed [DATA_W-1:0] value;
        logic                     overflow;
    } t_min_result;

    typedef enum logic [1:0] {
        VAL_FULL,
        VAL_NARROW,
        VAL_RISING,
        VAL_FALLING
    } t_value_mode;

    logic i_clk;
    logic i_rst_n;

    swmi_item_if   item_ch ();
    swmi_result_if result_ch ();
    swmi_cfg_if    cfg_ch ();

    sliding_window_min_index_core u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    // predictor state: window register, monotonic candidate list, position counter
    logic [WS_W-1:0]   window_reg;
    t_entry            window_cands[$];
    logic [DATA_W-1:0] next_pos;
    logic              pos_saturated;
    t_min_result       pending_minima[$];

    int mismatches   = 0;
    int samples_sent = 0;
    int idle_cycles  = 0;
    bit steady       = 1'b0;
    bit items_held   = 1'b1;

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    function automatic int effective_span(input logic [WS_W-1:0] w);
        if (w == '0) return 1;
        if (w > WINDOW_MAX) return WINDOW_MAX;
        return int'(w);
    endfunction

    // advances the candidate list by one sample and queues the minimum it yields
    function automatic void track_minimum(input logic signed [DATA_W-1:0] smp,
                                          input logic last);
        logic [63:0]       span;
        logic [DATA_W-1:0] pos;
        t_entry            cand;
        t_min_result       res;
        span = 64'(effective_span(window_reg));
        pos  = next_pos;
        if (next_pos == POS_MAX) pos_saturated = 1'b1;
        else next_pos = next_pos + 1'b1;

        // expired at the head
        while (window_cands.size() != 0 &&
               {32'd0, window_cands[0].pos} + span <= {32'd0, pos})
            void'(window_cands.pop_front());
        // strictly greater at the tail can never win again
        while (window_cands.size() != 0 &&
               $signed(window_cands[$].value) > $signed(smp))
            void'(window_cands.pop_back());
        if (window_cands.size() >= WINDOW_MAX) void'(window_cands.pop_front());
        cand.pos   = pos;
        cand.value = smp;
        window_cands = {window_cands, cand};

        if ({32'd0, pos} + 64'd1 >= span) begin
            res.pos      = window_cands[0].pos;
            res.value    = window_cands[0].value;
            res.overflow = pos_saturated;
            pending_minima = {pending_minima, res};
        end
        if (last) begin
            window_cands.delete();
            next_pos      = '0;
            pos_saturated = 1'b0;
        end
    endfunction

    task automatic hold_items();
        if (!items_held) begin
            item_ch.valid <= 1'b0;
            items_held = 1'b1;
        end
    endtask

    task automatic send_sample(input logic signed [DATA_W-1:0] smp, input logic last);
        while (!steady && $urandom_range(0, 99) < 25) begin
            hold_items();
            @(posedge i_clk);
        end
        item_ch.valid     <= 1'b1;
        item_ch.sample    <= smp;
        item_ch.last_item <= last;
        items_held = 1'b0;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
        track_minimum(smp, last);
        samples_sent++;
    endtask

    // stop sending until every queued minimum is back, optionally let the block settle
    task automatic wait_for_minima(input bit settle);
        hold_items();
        while (pending_minima.size() != 0) @(posedge i_clk);
        if (settle) repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_window(input logic [WS_W-1:0] w);
        wait_for_minima(1'b1);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= w;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        window_reg = w;
    endtask

    // window of one straight after reset, sample extremes
    task automatic test_default_window();
        send_sample(32'sh8000_0000, 1'b0);
        send_sample(32'sh7FFF_FFFF, 1'b0);
        send_sample(32'sh0000_0000, 1'b0);
        send_sample(-32'sd1, 1'b1);
    endtask

    // zero acts as one, oversized clamps to the largest window
    task automatic test_window_limits();
        write_window('0);
        send_sample(32'sh5555_5555, 1'b0);
        send_sample(32'shAAAA_AAAA, 1'b1);
        write_window('1);
        // too short to fill the window, nothing comes back
        send_sample(32'sd3, 1'b0);
        send_sample(-32'sd3, 1'b0);
        send_sample(32'sd1, 1'b1);
    endtask

    // equal values keep the earliest position until it leaves the window
    task automatic test_ties_and_expiry();
        write_window(7'd3);
        send_sample(32'sd5, 1'b0);
        send_sample(32'sd5, 1'b0);
        send_sample(32'sd5, 1'b0);
        send_sample(32'sd2, 1'b0);
        send_sample(32'sd7, 1'b0);
        send_sample(32'sd7, 1'b0);
        send_sample(32'sd7, 1'b1);
    endtask

    // shrink the window part way through a sequence
    task automatic test_resize_midsequence();
        write_window(7'd4);
        send_sample(32'sd9, 1'b0);
        send_sample(32'sd4, 1'b0);
        send_sample(32'sd8, 1'b0);
        send_sample(32'sd6, 1'b0);
        send_sample(32'sd3, 1'b0);
        write_window(7'd2);
        send_sample(32'sd7, 1'b0);
        send_sample(32'sd8, 1'b0);
        send_sample(32'sd1, 1'b1);
    endtask

    // sequences of random shape under random window sizes, some run across resizes
    task automatic test_random_streams();
        int                       start;
        int                       span;
        int                       len;
        int                       step;
        t_value_mode              mode;
        logic signed [DATA_W-1:0] val;
        logic [WS_W-1:0]          w;
        logic                     last;
        start = samples_sent;
        while (samples_sent - start < RANDOM_SAMPLES) begin
            case ($urandom_range(0, 15))
                0:       w = '0;
                1:       w = '1;
                2:       w = WS_W'(WINDOW_MAX);
                3:       w = WS_W'(WINDOW_MAX + 1);
                4:       w = WS_W'($urandom_range(9, WINDOW_MAX - 1));
                default: w = WS_W'($urandom_range(1, 8));
            endcase
            write_window(w);
            span = effective_span(w);
            repeat ($urandom_range(1, 3)) begin
                steady = (samples_sent - start >= 450) && (samples_sent - start < 650);
                if ($urandom_range(0, 7) == 0) len = $urandom_range(1, span);
                else len = span + $urandom_range(0, 20);
                mode = t_value_mode'($urandom_range(0, 3));
                val  = $urandom;
                step = $urandom_range(1, 1000);
                for (int i = 0; i < len; i++) begin
                    case (mode)
                        VAL_FULL:    val = $urandom;
                        VAL_NARROW:  val = int'($urandom_range(0, 6)) - 3;
                        VAL_RISING:  val = val + step;
                        VAL_FALLING: val = val - step;
                        default:     val = $urandom;
                    endcase
                    // mostly closed at the end, rarely cut short, sometimes left open
                    if (i == len - 1) last = ($urandom_range(0, 3) != 0);
                    else last = ($urandom_range(0, 39) == 0);
                    send_sample(val, last);
                end
            end
            if ($urandom_range(0, 3) == 0) wait_for_minima(1'b0);
        end
        steady = 1'b0;
    endtask

    // result side: random back-pressure, compare against the oldest queued minimum
    always @(posedge i_clk) begin : check_results
        t_min_result want;
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
            idle_cycles     <= 0;
        end else begin
            result_ch.ready <= steady || ($urandom_range(0, 99) >= 25);
            if ((item_ch.valid && item_ch.ready) || (cfg_ch.valid && cfg_ch.ready) ||
                (result_ch.valid && result_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (result_ch.valid && result_ch.ready) begin
                if (pending_minima.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected result: pos %0d value %0d overflow %0b",
                                 result_ch.min_position, result_ch.min_value,
                                 result_ch.position_overflow);
                end else begin
                    want = pending_minima.pop_front();
                    if (result_ch.min_position !== want.pos ||
                        result_ch.min_value !== want.value ||
                        result_ch.position_overflow !== want.overflow) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("result mismatch: expected %0d %0d %0b, got %0d %0d %0b",
                                     want.pos, want.value, want.overflow,
                                     result_ch.min_position, result_ch.min_value,
                                     result_ch.position_overflow);
                    end
                end
            end
        end
    end

    initial begin : watchdog
        while (idle_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("sliding_window_min_index_core verification failed");
        $finish;
    end

    initial begin
        i_rst_n           <= 1'b0;
        item_ch.valid     <= 1'b0;
        item_ch.sample    <= '0;
        item_ch.last_item <= 1'b0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.data       <= '0;
        window_reg    = WS_W'(1);
        next_pos      = '0;
        pos_saturated = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_window();
        test_window_limits();
        test_ties_and_expiry();
        test_resize_midsequence();
        test_random_streams();

        wait_for_minima(1'b1);
        if (mismatches == 0 && pending_minima.size() == 0)
            $display("sliding_window_min_index_core verification clean");
        else
            $display("sliding_window_min_index_core verification failed");
        $finish;
    end

endmodule
